[rtl/pfr_pkg.sv]
package pfr_pkg;

   // Fixed field widths of the request and response items
   localparam int PID_W = 4;
   localparam int ACT_W = 2;
   localparam int ST_W  = 2;

   // Default number of process ids
   localparam int NUM_PROCS_DEF = 16;

   typedef logic [ACT_W-1:0] action_type;
   typedef logic [ST_W-1:0]  status_type;

   // Action codes
   localparam action_type ACT_ENQ = 2'd0;
   localparam action_type ACT_DEQ = 2'd1;
   localparam action_type ACT_REM = 2'd2;

   // Status codes
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_NOTFOUND = 2'd2;
   localparam status_type ST_DUP      = 2'd3;

endpackage

[rtl/pfr_ram.sv]
module pfr_ram
   import pfr_pkg::*;
#(
   parameter int WIDTH = PID_W + 1,
   parameter int DEPTH = NUM_PROCS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pid_fifo_with_remove.sv]
// FIFO of process ids held as a singly linked list. Each id owns one entry of a
// link memory (next id plus an end-of-list flag); head, tail, an empty flag and
// one queued bit per id live in flip-flops, and reset clears them at once, so
// no clearing pass is needed. Raise start with req_action and req_pid while
// busy is low; the item is taken at that edge. Exactly one result follows per
// item, shown on the rsp_ ports for a single cycle while rsp_valid is high; it
// cannot be held off, so capture it then. Each item takes these steps, set by the
// single read port of the link memory, which the sequencer uses once per cycle:
//   rejected items, unused action code, enqueue into an empty queue: answered
//   from the idle state; enqueue onto a non-empty queue: the link state;
//   dequeue, remove of the head: the head entry is read, then the dequeue state;
//   remove of the entry k links behind the head: the walk state follows the
//   links up to its predecessor, then the unlink state.
// busy falls in the cycle the result is shown, so the next item may be taken
// at the edge that ends it. An enqueue of an id that is already queued is
// rejected with status 3 and leaves the list untouched.
module pid_fifo_with_remove
   import pfr_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [ACT_W-1:0] req_action,
   input  logic [PID_W-1:0] req_pid,
   output logic             rsp_valid,
   output logic [PID_W-1:0] rsp_result_pid,
   output logic [ST_W-1:0]  rsp_status,
   output logic             rsp_queue_empty
);

   localparam int IdW   = $clog2(NUM_PROCS);
   localparam int LinkW = IdW + 1;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ENQ    = 3'd1;
   localparam logic [2:0] S_DEQ    = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [IdW-1:0]       op_pid_ff, op_pid_in;
   logic [IdW-1:0]       cur_ff, cur_in;
   logic [IdW-1:0]       head_ff, head_in;
   logic [IdW-1:0]       tail_ff, tail_in;
   logic                 empty_ff, empty_in;
   logic [NUM_PROCS-1:0] queued_ff, queued_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PID_W-1:0]     rsp_pid_ff, rsp_pid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic                 ram_wr_en;
   logic [IdW-1:0]       ram_wr_addr;
   logic [LinkW-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [IdW-1:0]       ram_rd_addr;
   logic [LinkW-1:0]     ram_rd_data;

   logic [IdW-1:0]       req_id;
   logic                 req_ok;
   logic                 rd_end;
   logic [IdW-1:0]       rd_next;

   // Link memory: entry = {end of list, next id}
   pfr_ram #(
      .WIDTH (LinkW),
      .DEPTH (NUM_PROCS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_id  = IdW'(req_pid);
   assign req_ok  = int'(req_pid) < NUM_PROCS;
   assign rd_end  = ram_rd_data[IdW];
   assign rd_next = ram_rd_data[IdW-1:0];

   // Only one item is in flight, so a memory entry is never read and written
   // in the same cycle; no forwarding path is required.
   always_comb begin
      state_in      = state_ff;
      op_pid_in     = op_pid_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      queued_in     = queued_ff;
      rsp_valid_in  = 1'b0;
      rsp_pid_in    = '0;
      rsp_status_in = ST_OK;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_pid_in = req_id;
               case (req_action)
                  ACT_ENQ: begin
                     if (!req_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else if (queued_ff[req_id]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_DUP;
                     end else begin
                        // write the new entry as the list end
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = req_id;
                        ram_wr_data       = {1'b1, {IdW{1'b0}}};
                        queued_in[req_id] = 1'b1;
                        if (empty_ff) begin
                           head_in      = req_id;
                           tail_in      = req_id;
                           empty_in     = 1'b0;
                           rsp_valid_in = 1'b1;
                        end else begin
                           state_in = S_ENQ;
                        end
                     end
                  end
                  ACT_DEQ: begin
                     if (empty_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        cur_in      = head_ff;
                        state_in    = S_DEQ;
                     end
                  end
                  ACT_REM: begin
                     if (empty_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else if (!req_ok || !queued_ff[req_id]) begin
                        // an id that is not marked queued is not on the list
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        cur_in      = head_ff;
                        state_in    = (req_id == head_ff) ? S_DEQ : S_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ENQ: begin
            // link the old tail to the new entry
            ram_wr_en    = 1'b1;
            ram_wr_addr  = tail_ff;
            ram_wr_data  = {1'b0, op_pid_ff};
            tail_in      = op_pid_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DEQ: begin
            if (rd_end) begin
               empty_in = 1'b1;
               head_in  = '0;
               tail_in  = '0;
            end else begin
               head_in = rd_next;
            end
            queued_in[cur_ff] = 1'b0;
            rsp_valid_in      = 1'b1;
            rsp_pid_in        = PID_W'(cur_ff);
            state_in          = S_IDLE;
         end
         S_WALK: begin
            // cur_ff holds the entry just read; stop one link ahead of the target
            ram_rd_en = 1'b1;
            if (rd_next == op_pid_ff) begin
               ram_rd_addr = op_pid_ff;
               state_in    = S_UNLINK;
            end else begin
               ram_rd_addr = rd_next;
               cur_in      = rd_next;
            end
         end
         S_UNLINK: begin
            // copy the target's link into its predecessor
            ram_wr_en            = 1'b1;
            ram_wr_addr          = cur_ff;
            ram_wr_data          = ram_rd_data;
            if (op_pid_ff == tail_ff) begin
               tail_in = cur_ff;
            end
            queued_in[op_pid_ff] = 1'b0;
            rsp_valid_in         = 1'b1;
            rsp_pid_in           = PID_W'(op_pid_ff);
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_empty_in = empty_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      op_pid_ff     <= op_pid_in;
      cur_ff        <= cur_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_pid  = rsp_pid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_empty = rsp_empty_ff;

   // An empty queue has its ends parked at zero and no id marked
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0 && queued_ff == '0))
      else $error("empty queue with live head, tail or queued bits");

   // Both ends of a non-empty list are queued ids
   a_ends_queued: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (queued_ff[head_ff] && queued_ff[tail_ff]))
      else $error("head or tail not marked queued");

   // The remove target stays queued for the whole walk
   a_walk_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK || state_ff == S_UNLINK) |-> queued_ff[op_pid_ff])
      else $error("remove target lost during walk");

   // A failed item returns id zero
   a_fail_pid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_pid_ff == '0))
      else $error("non-zero id on failed item");

   // A result is shown only when the sequencer is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while busy");

endmodule
